/* rtl/kwmh_pkg.sv */
// ----------------------------------------------------------------------------
// K-way merge min-heap package
// Widths, operation and status codes, request and result types, and the
// entry ordering used by the heap; the checker shares the codes and types.
// ----------------------------------------------------------------------------
package kwmh_pkg;

  localparam int FAN_IN = 32;
  localparam int IDX_W  = $clog2(FAN_IN);
  localparam int CNT_W  = $clog2(FAN_IN + 1);
  localparam int POS_W  = IDX_W + 2;
  localparam int OCC_W  = 6;

  localparam logic [1:0] FUNC_PUSH    = 2'd0;
  localparam logic [1:0] FUNC_REPLACE = 2'd1;
  localparam logic [1:0] FUNC_POP     = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] id;
    logic [4:0]  source;
  } entry_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] entry_key;
    logic [63:0] entry_id;
    logic [4:0]  entry_source;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             removed_valid;
    logic [63:0]      removed_key;
    logic [63:0]      removed_id;
    logic [4:0]       removed_source;
    logic [OCC_W-1:0] occupancy;
  } out_rsp_t;

  // Entries order by key, then id, then source; the packed layout matches.
  function automatic logic entry_before(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage

/* rtl/kway_merge_min_heap_top.sv */
// ----------------------------------------------------------------------------
// K-way merge min-heap
// Binary min-heap of up to FAN_IN run heads in one dual-read memory, with
// push (sift up), replace minimum and pop minimum (sift down).
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+----------------------------
//  input   | in_valid, in_stall, in_data    | one heap operation request
//  output  | out_valid, out_stall, out_data | one result per request
//
// One request is worked at a time; in_stall is low only while the block is idle.
// Push reads the parent and compares at each level climbed. Replace and pop
// read the root and the last entry, then at each level descended read both
// children, select the smaller and compare; a pop that empties the heap skips
// the descent. Each level costs a registered memory read plus a compare.
// Reset clears the state, the entry count and the output valid only; the memory needs no clearing pass.
// A stalled result holds the next request at its last step until it is taken.
module kway_merge_min_heap_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kwmh_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kwmh_pkg::out_rsp_t out_data
);
  import kwmh_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_UP_RD    = 9'b000000010,
    S_UP_CMP   = 9'b000000100,
    S_ROOT_RD  = 9'b000001000,
    S_ROOT_CAP = 9'b000010000,
    S_DN_RD    = 9'b000100000,
    S_DN_SEL   = 9'b001000000,
    S_DN_CMP   = 9'b010000000,
    S_EMIT     = 9'b100000000
  } state_t;

  entry_t heap_mem [FAN_IN];
  entry_t rd0_r, rd1_r;

  state_t           state_r, state_nxt;
  logic [1:0]       func_r, func_nxt;
  entry_t           cur_r, cur_nxt;
  entry_t           child_r, child_nxt;
  logic [IDX_W-1:0] child_idx_r, child_idx_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  out_rsp_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;

  logic             we_c;
  logic [IDX_W-1:0] wr_addr_c, rd0_addr_c, rd1_addr_c;
  entry_t           wr_data_c;

  logic [IDX_W-1:0] parent_c;
  logic [CNT_W-1:0] last_c;
  logic [POS_W-1:0] left_c, right_c, cnt_w_c;
  logic             right_ok_c;
  logic             move_c;

  assign parent_c   = (pos_r - IDX_W'(1)) >> 1;
  assign last_c     = cnt_r - CNT_W'(1);
  assign left_c     = {1'b0, pos_r, 1'b1};
  assign right_c    = left_c + POS_W'(1);
  assign cnt_w_c    = POS_W'(cnt_r);
  assign right_ok_c = right_c < cnt_w_c;
  // Replace keeps walking while the child is strictly smaller; pop walks
  // past an equal child as well.
  assign move_c     = (func_r == FUNC_POP) ? !entry_before(cur_r, child_r)
                                           : entry_before(child_r, cur_r);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    cur_nxt       = cur_r;
    child_nxt     = child_r;
    child_idx_nxt = child_idx_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    we_c          = 1'b0;
    wr_addr_c     = pos_r;
    wr_data_c     = cur_r;
    rd0_addr_c    = '0;
    rd1_addr_c    = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          cur_nxt    = '{key: in_data.entry_key, id: in_data.entry_id,
                         source: in_data.entry_source};
          res_nxt    = '0;
          res_nxt.status = ST_OK;
          case (in_data.func)
            FUNC_PUSH: begin
              if (cnt_r >= CNT_W'(FAN_IN)) begin
                res_nxt.status = ST_FULL;
                state_nxt      = S_EMIT;
              end else begin
                pos_nxt   = cnt_r[IDX_W-1:0];
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_UP_RD;
              end
            end
            FUNC_REPLACE, FUNC_POP: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_EMIT;
              end else begin
                state_nxt = S_ROOT_RD;
              end
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we_c      = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          rd0_addr_c = parent_c;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we_c = 1'b1;
        if (entry_before(rd0_r, cur_r)) begin
          state_nxt = S_EMIT;
        end else begin
          wr_data_c = rd0_r;
          pos_nxt   = parent_c;
          state_nxt = S_UP_RD;
        end
      end
      S_ROOT_RD: begin
        rd0_addr_c = '0;
        rd1_addr_c = last_c[IDX_W-1:0];
        state_nxt  = S_ROOT_CAP;
      end
      S_ROOT_CAP: begin
        res_nxt.removed_valid  = 1'b1;
        res_nxt.removed_key    = rd0_r.key;
        res_nxt.removed_id     = rd0_r.id;
        res_nxt.removed_source = rd0_r.source;
        pos_nxt                = '0;
        state_nxt              = S_DN_RD;
        if (func_r == FUNC_POP) begin
          cur_nxt = rd1_r;
          cnt_nxt = last_c;
          if (last_c == '0) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DN_RD: begin
        if (left_c >= cnt_w_c) begin
          we_c      = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          rd0_addr_c = left_c[IDX_W-1:0];
          rd1_addr_c = right_ok_c ? right_c[IDX_W-1:0] : left_c[IDX_W-1:0];
          state_nxt  = S_DN_SEL;
        end
      end
      S_DN_SEL: begin
        if (right_ok_c && entry_before(rd1_r, rd0_r)) begin
          child_nxt     = rd1_r;
          child_idx_nxt = right_c[IDX_W-1:0];
        end else begin
          child_nxt     = rd0_r;
          child_idx_nxt = left_c[IDX_W-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we_c = 1'b1;
        if (move_c) begin
          wr_data_c = child_r;
          pos_nxt   = child_idx_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = res_r;
          out_data_nxt.occupancy = OCC_W'(cnt_r);
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      heap_mem[wr_addr_c] <= wr_data_c;
    end
    rd0_r <= heap_mem[rd0_addr_c];
    rd1_r <= heap_mem[rd1_addr_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    cur_r       <= cur_nxt;
    child_r     <= child_nxt;
    child_idx_r <= child_idx_nxt;
    pos_r       <= pos_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/kwmh_checker.sv */
// ----------------------------------------------------------------------------
// K-way merge min-heap port checker
// Watches the heap's ports for result consistency and input and output handshake rules.
// ----------------------------------------------------------------------------
module kwmh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input kwmh_pkg::out_rsp_t out_data
);
  import kwmh_pkg::*;

  // A taken request keeps the input side busy while it is worked.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input free right after a request was taken");

  // A result that waits must stay put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Only a successful replace or pop emits an entry.
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.removed_valid |-> out_data.status == ST_OK)
    else $error("entry emitted with an error status");

  // Without a removal the emitted entry fields are zero.
  a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.removed_valid |->
      out_data.removed_key == '0 && out_data.removed_id == '0 &&
      out_data.removed_source == '0)
    else $error("entry fields set without a removal");

  // An empty report always comes with an empty heap.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.occupancy == '0)
    else $error("empty status with nonzero occupancy");

endmodule

bind kway_merge_min_heap_top kwmh_checker u_kwmh_checker (.*);
